// ----- hw/rtl/flash_memory_protection_unit_defines.svh -----
// Assertion macros shared by the flash memory protection unit RTL.
`ifndef FLASH_MEMORY_PROTECTION_UNIT_DEFINES_SVH
`define FLASH_MEMORY_PROTECTION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FMPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define FMPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fmpu_pkg.sv -----
// Package: constants, codes and types of the flash memory protection unit.
`timescale 1ns / 1ps
`default_nettype none
package fmpu_pkg;

  localparam int RAM_EXEC_PAGES_DEF = 64;
  localparam int COUNT_WIDTH_DEF    = 8;

  localparam int ADDR_W = 24;
  localparam int CMP_W  = 27;   // room for base + slid bound without wrap

  // access kinds
  typedef enum logic [1:0] {
    FN_FETCH     = 2'd0,
    FN_READ_BYTE = 2'd1,
    FN_READ_WORD = 2'd2,
    FN_WRITE     = 2'd3
  } func_t;

  // violation codes
  typedef enum logic [1:0] {
    VIO_NONE     = 2'd0,
    VIO_ARCHIVE  = 2'd1,
    VIO_RAM_EXEC = 2'd2,
    VIO_FL_EXEC  = 2'd3
  } vio_t;

  // configuration register indexes
  localparam logic [2:0] CFG_HW_MODE     = 3'd0;
  localparam logic [2:0] CFG_FLASH_BASE  = 3'd1;
  localparam logic [2:0] CFG_FLASH_SIZE  = 3'd2;
  localparam logic [2:0] CFG_RAM_NOEXEC  = 3'd3;
  localparam logic [2:0] CFG_HIGH_NOEXEC = 3'd4;
  localparam logic [2:0] CFG_EXEC_LIMIT  = 3'd5;

  // reset values of configuration
  localparam logic [23:0] FLASH_BASE_RST = 24'h200000;
  localparam logic [22:0] FLASH_SIZE_RST = 23'h200000;
  localparam logic [7:0]  EXEC_LIMIT_RST = 8'h18;

  // slid region bounds, before adding the flash base
  localparam logic [CMP_W-1:0] SLIDE_ADJ   = 27'h0200000;
  localparam logic [CMP_W-1:0] ARCH_LO     = 27'h0390000;
  localparam logic [CMP_W-1:0] ARCH_HI     = 27'h03fffff;
  localparam logic [CMP_W-1:0] FLASH_LO    = 27'h0210000;
  localparam logic [CMP_W-1:0] FLASH_HI_M1 = 27'h01fffff;
  localparam logic [CMP_W-1:0] CERT_LO     = 27'h0200000;
  localparam logic [CMP_W-1:0] CERT_HI     = 27'h021ffff;

  // offsets inside the certificate window
  localparam logic [16:0] OFS_GAP1_END = 17'h12000;
  localparam logic [16:0] OFS_GAP2_LO  = 17'h18000;
  localparam logic [16:0] OFS_GAP2_END = 17'h1a000;

  localparam logic [15:0] PATTERN_BYTE = 16'h0014;
  localparam logic [15:0] PATTERN_WORD = 16'h1414;

endpackage
`default_nettype wire

// ----- hw/rtl/flash_memory_protection_unit.sv -----
// Top level: flash memory protection unit, judges each bus access.
`timescale 1ns / 1ps
`default_nettype none
// Flash memory protection unit.
//
// Input stream (s_axis): one beat per bus access. tuser carries the access
// kind (fetch, byte read, word read, byte write), tdata the 24-bit address.
// Output stream (m_axis): one result beat per access, in order: freeze,
// violation code, read override flag and pattern, write drop, and the
// protect flag as it stands after the access.
// Configuration channel (cfg_*): register index plus 64-bit data, always
// ready; write only while no access is in flight.
//
// Each access passes through the input register; classification, the state
// update and the result register follow. Throughput is one beat per cycle
// while the receiver accepts results; the protect flag, archive-limit bits
// and counters are updated in the same cycle the result is registered, so
// a following beat sees them at once.
// When the receiver stalls, the result register holds and the input
// register absorbs one more beat before s_axis_tready drops.
// Reset (rst, synchronous, active high) clears the valid flags, the
// protect flag, the archive-limit bits and all counters, and loads the
// configuration registers with their defaults.
`include "flash_memory_protection_unit_defines.svh"

module flash_memory_protection_unit #(
  parameter int RAM_EXEC_PAGES = fmpu_pkg::RAM_EXEC_PAGES_DEF,
  parameter int COUNT_WIDTH    = fmpu_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [23:0] addr
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] freeze, [2:1] violation, [3] read_override, [19:4] override_data,
  // [20] write_drop, [21] protect_on, [23:22] zero
  output logic [23:0]      m_axis_tdata,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int CW = COUNT_WIDTH;
  localparam int CMP_W = fmpu_pkg::CMP_W;

  // ---------------- configuration registers
  logic                      hw_mode;
  logic [23:0]               flash_base;
  logic [22:0]               flash_size;
  logic [RAM_EXEC_PAGES-1:0] noexec_mask;
  logic                      high_noexec;
  logic [7:0]                exec_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hw_mode     <= 1'b0;
      flash_base  <= fmpu_pkg::FLASH_BASE_RST;
      flash_size  <= fmpu_pkg::FLASH_SIZE_RST;
      noexec_mask <= '0;
      high_noexec <= 1'b0;
      exec_limit  <= fmpu_pkg::EXEC_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fmpu_pkg::CFG_HW_MODE:     hw_mode     <= cfg_data[0];
        fmpu_pkg::CFG_FLASH_BASE:  flash_base  <= cfg_data[23:0];
        fmpu_pkg::CFG_FLASH_SIZE:  flash_size  <= cfg_data[22:0];
        fmpu_pkg::CFG_RAM_NOEXEC:  noexec_mask <= cfg_data[RAM_EXEC_PAGES-1:0];
        fmpu_pkg::CFG_HIGH_NOEXEC: high_noexec <= cfg_data[0];
        fmpu_pkg::CFG_EXEC_LIMIT:  exec_limit  <= cfg_data[7:0];
        default: ;  // unknown index: drop
      endcase
    end
  end

  // ---------------- input register
  logic            in_vld;
  fmpu_pkg::func_t in_func;
  logic [23:0]     in_addr;
  logic            advance;

  assign advance       = in_vld && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func <= fmpu_pkg::func_t'(s_axis_tuser);
      in_addr <= s_axis_tdata;
    end
  end

  // ---------------- protection state
  logic          protect_flag, protect_flag_next;
  logic [2:0]    arch_bits, arch_bits_next;
  logic [CW-1:0] auth_first, auth_first_next;
  logic [CW-1:0] auth_second, auth_second_next;
  logic [CW-1:0] enable_hits, enable_hits_next;
  logic [CW-1:0] overrun_hits, overrun_hits_next;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c, input logic [1:0] n);
    logic [CW:0] s;
    s = {1'b0, c} + (CW+1)'(n);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // slid bound compares: addr + 0x200000 against base + bound
  logic [CMP_W-1:0] addr_adj, base_ext;
  logic in_arch, in_flash, flash_noexec, in_cert;

  always_comb begin
    addr_adj = CMP_W'(in_addr) + fmpu_pkg::SLIDE_ADJ;
    base_ext = CMP_W'(flash_base);
    in_arch  = (addr_adj >= base_ext + fmpu_pkg::ARCH_LO + CMP_W'({arch_bits, 16'h0000}))
            && (addr_adj <= base_ext + fmpu_pkg::ARCH_HI);
    in_flash = (addr_adj >= base_ext + fmpu_pkg::FLASH_LO)
            && (addr_adj <= base_ext + fmpu_pkg::FLASH_HI_M1 + CMP_W'(flash_size));
    flash_noexec = addr_adj >= base_ext + fmpu_pkg::FLASH_LO + CMP_W'({exec_limit, 16'h0000});
    in_cert  = (addr_adj >= base_ext + fmpu_pkg::CERT_LO)
            && (addr_adj <= base_ext + fmpu_pkg::CERT_HI);
  end

  // fixed regions
  logic       rg_low_ram, rg_ram, rg_arch_ctl, rg_screen, rg_auth_port;
  logic [5:0] page;
  logic [63:0] mask_ext;
  logic       page_noexec;
  logic [1:0] arch_idx;
  logic [16:0] ofs;
  logic       cert_auth;

  always_comb begin
    rg_low_ram   = in_addr[23:18] == 6'h00;               // 0x000000..0x03ffff
    rg_ram       = in_addr[23:21] == 3'h0;                // 0x000000..0x1fffff
    rg_arch_ctl  = (in_addr[23:20] == 4'h0) && (in_addr[19:18] != 2'b00);
    rg_screen    = in_addr[23:18] == 6'h06;               // 0x180000..0x1bffff
    rg_auth_port = in_addr[23:18] == 6'h07;               // 0x1c0000..0x1fffff
    page         = in_addr[17:12];
    mask_ext     = 64'(noexec_mask);
    page_noexec  = (7'(page) < 7'(RAM_EXEC_PAGES)) && mask_ext[page];
    arch_idx     = in_addr[19:18] - 2'd1;
    ofs          = 17'(in_addr - flash_base);
    cert_auth    = !ofs[16]
                || ((ofs >= fmpu_pkg::OFS_GAP1_END) && (ofs < fmpu_pkg::OFS_GAP2_LO))
                || (ofs >= fmpu_pkg::OFS_GAP2_END);
  end

  // ---------------- per-access decision
  logic            r_freeze;
  fmpu_pkg::vio_t  r_vio;
  logic            r_ovr;
  logic [15:0]     r_data;
  logic            r_drop;
  logic            is_word, is_wr, counts, hw1, hit;

  always_comb begin
    protect_flag_next = protect_flag;
    arch_bits_next    = arch_bits;
    auth_first_next   = auth_first;
    auth_second_next  = auth_second;
    enable_hits_next  = enable_hits;
    overrun_hits_next = overrun_hits;
    r_freeze = 1'b0;
    r_vio    = fmpu_pkg::VIO_NONE;
    r_ovr    = 1'b0;
    r_data   = '0;
    r_drop   = 1'b0;
    hit      = 1'b0;
    is_word  = in_func == fmpu_pkg::FN_READ_WORD;
    is_wr    = in_func == fmpu_pkg::FN_WRITE;
    counts   = is_word || !in_addr[0];
    hw1      = !hw_mode;

    if (in_func == fmpu_pkg::FN_FETCH) begin
      if (hw1) begin
        if (in_arch) begin
          if (!in_addr[0]) overrun_hits_next = sat_add(overrun_hits, 2'd1);
          if (overrun_hits_next >= CW'(4)) begin
            r_freeze = 1'b1;
            r_vio    = fmpu_pkg::VIO_ARCHIVE;
          end
        end
      end else if (rg_low_ram) begin
        if (page_noexec) begin
          r_freeze = 1'b1;
          r_vio    = fmpu_pkg::VIO_RAM_EXEC;
        end
      end else if (rg_ram) begin
        if (high_noexec) begin
          r_freeze = 1'b1;
          r_vio    = fmpu_pkg::VIO_RAM_EXEC;
        end
      end else if (in_flash && flash_noexec) begin
        r_freeze = 1'b1;
        r_vio    = fmpu_pkg::VIO_FL_EXEC;
      end
    end else if (rg_arch_ctl) begin
      if (!protect_flag && hw1) begin
        arch_bits_next[arch_idx] = is_wr;
      end
    end else if (rg_screen) begin
      // screen power control: nothing to judge
    end else if (rg_auth_port) begin
      if (is_word) begin
        auth_second_next = sat_add(auth_second, 2'd2);
        hit = (auth_first >= CW'(3)) || (auth_second_next >= CW'(7));
      end else begin
        hit = auth_first >= CW'(3);
        if (!hit) begin
          auth_second_next = sat_add(auth_second, 2'd1);
          hit = auth_second_next >= CW'(7);
        end
      end
      if (hit) begin
        protect_flag_next = !is_wr;
        auth_first_next   = '0;
        auth_second_next  = '0;
      end else if (hw1) begin
        if (counts) enable_hits_next = sat_add(enable_hits, 2'd1);
        if (enable_hits_next >= CW'(4)) r_freeze = 1'b1;
      end
    end else if (in_cert) begin
      if (cert_auth) begin
        if (counts) begin
          if (hw1) auth_first_next  = sat_add(auth_first, 2'd1);
          else     auth_second_next = sat_add(auth_second, 2'd1);
        end
        if (is_wr && !ofs[16]) r_drop = 1'b1;
      end else if (!is_wr && protect_flag) begin
        r_ovr  = 1'b1;
        r_data = is_word ? fmpu_pkg::PATTERN_WORD : fmpu_pkg::PATTERN_BYTE;
      end
    end else begin
      // access outside every region: restart all counting
      auth_first_next   = '0;
      auth_second_next  = '0;
      enable_hits_next  = '0;
      overrun_hits_next = '0;
    end

    // freeze clears the authentication and enable counters
    if (r_freeze) begin
      auth_first_next  = '0;
      auth_second_next = '0;
      enable_hits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protect_flag <= 1'b0;
      arch_bits    <= '0;
      auth_first   <= '0;
      auth_second  <= '0;
      enable_hits  <= '0;
      overrun_hits <= '0;
    end else if (advance) begin
      protect_flag <= protect_flag_next;
      arch_bits    <= arch_bits_next;
      auth_first   <= auth_first_next;
      auth_second  <= auth_second_next;
      enable_hits  <= enable_hits_next;
      overrun_hits <= overrun_hits_next;
    end
  end

  // ---------------- result register
  logic           res_freeze;
  fmpu_pkg::vio_t res_vio;
  logic           res_ovr;
  logic [15:0]    res_data;
  logic           res_drop;
  logic           res_protect;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_freeze  <= r_freeze;
      res_vio     <= r_vio;
      res_ovr     <= r_ovr;
      res_data    <= r_data;
      res_drop    <= r_drop;
      res_protect <= protect_flag_next;
    end
  end

  assign m_axis_tdata = {2'b00, res_protect, res_drop, res_data, res_ovr, res_vio, res_freeze};

  // ---------------- assertions
  `FMPU_ASSERT_NOW(a_pattern_only_on_override, m_axis_tvalid, res_ovr == (res_data != 16'h0000), "override pattern without override flag")
  `FMPU_ASSERT_NOW(a_drop_excludes_override, m_axis_tvalid && res_drop, !res_ovr, "write drop together with read override")
  `FMPU_ASSERT_NEXT(a_freeze_clears_counters, advance && r_freeze, (auth_first == '0) && (auth_second == '0) && (enable_hits == '0), "freeze left counters set")
  `FMPU_ASSERT_NEXT(a_arch_bits_locked, advance && protect_flag, $stable(arch_bits), "archive-limit bits changed while protected")

endmodule
`default_nettype wire

// ----- tb/flash_memory_protection_unit_checker.sv -----
// Checker: predicts every result beat of the protection unit and compares it field by field.
`timescale 1ns / 1ps
module flash_memory_protection_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] addr
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] freeze, [2:1] violation, [3] read_override, [19:4] override_data,
  // [20] write_drop, [21] protect_on
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          results,
  output int          freezes,
  output int          overrides,
  output int          drops,
  output int          archive_hits,
  output int          ram_exec_hits,
  output int          flash_exec_hits
);
  import fmpu_pkg::*;

  localparam int     CNT_MAX   = (1 << COUNT_WIDTH_DEF) - 1;
  localparam longint SLIDE_REF = 2097152;

  typedef struct packed {
    logic        freeze;
    vio_t        vio;
    logic        ovr;
    logic [15:0] pattern;
    logic        drop;
    logic        prot;
  } verdict_t;

  // register copy
  logic        rev2;
  logic [23:0] base;
  logic [22:0] fsize;
  logic [63:0] page_nx;
  logic        high_nx;
  logic [7:0]  exec_pages;

  // block state copy
  logic        prot;
  logic [2:0]  arch_bits;
  logic [7:0]  cert_hits;
  logic [7:0]  gate_hits;
  logic [7:0]  port_hits;
  logic [7:0]  overrun_hits;

  verdict_t verdicts_due[$];

  function automatic logic [7:0] bump(input logic [7:0] c, input int n);
    int s;
    s = int'(c) + n;
    return (s > CNT_MAX) ? 8'(CNT_MAX) : 8'(s);
  endfunction

  // region bound moved by the flash base, kept wide so it never wraps
  function automatic longint slide(input longint a);
    return a + longint'(base) - SLIDE_REF;
  endfunction

  function automatic void freeze_clear();
    cert_hits = '0;
    gate_hits = '0;
    port_hits = '0;
  endfunction

  function automatic verdict_t judge_access(input func_t fn, input logic [23:0] a);
    verdict_t r;
    longint   v;
    longint   o;
    logic     word;
    logic     wr;
    logic     counts;
    logic     hit;
    int       bitn;
    r = '0;
    v = longint'(a);
    word = (fn == FN_READ_WORD);
    wr = (fn == FN_WRITE);
    counts = word || !a[0];
    if (fn == FN_FETCH) begin
      if (!rev2) begin
        if (v >= slide(64'sh390000 + longint'(arch_bits) * 64'sh10000) &&
            v <= slide(64'sh3fffff)) begin
          if (!a[0]) overrun_hits = bump(overrun_hits, 1);
          if (overrun_hits >= 4) begin
            freeze_clear();
            r.freeze = 1'b1;
            r.vio = VIO_ARCHIVE;
          end
        end
      end else if (a <= 24'h03ffff) begin
        if (page_nx[a[17:12]]) begin
          freeze_clear();
          r.freeze = 1'b1;
          r.vio = VIO_RAM_EXEC;
        end
      end else if (a <= 24'h1fffff) begin
        if (high_nx) begin
          freeze_clear();
          r.freeze = 1'b1;
          r.vio = VIO_RAM_EXEC;
        end
      end else if (v >= slide(64'sh210000) &&
                   v <= slide(64'sh1fffff + longint'(fsize))) begin
        if (v >= slide(64'sh210000 + longint'(exec_pages) * 64'sh10000)) begin
          freeze_clear();
          r.freeze = 1'b1;
          r.vio = VIO_FL_EXEC;
        end
      end
    end else if (a >= 24'h040000 && a <= 24'h0fffff) begin
      bitn = int'(a[23:18]) - 1;
      if (!prot && !rev2) arch_bits[bitn] = wr;
    end else if (a >= 24'h180000 && a <= 24'h1bffff) begin
      // screen power window: no effect on protection
    end else if (a >= 24'h1c0000 && a <= 24'h1fffff) begin
      if (word) begin
        gate_hits = bump(gate_hits, 2);
        hit = (cert_hits >= 3) || (gate_hits >= 7);
      end else begin
        hit = (cert_hits >= 3);
        if (!hit) begin
          gate_hits = bump(gate_hits, 1);
          hit = (gate_hits >= 7);
        end
      end
      if (hit) begin
        prot = !wr;
        cert_hits = '0;
        gate_hits = '0;
      end else if (!rev2) begin
        if (counts) port_hits = bump(port_hits, 1);
        if (port_hits >= 4) begin
          freeze_clear();
          r.freeze = 1'b1;
        end
      end
    end else if (v >= slide(64'sh200000) && v <= slide(64'sh21ffff)) begin
      o = v - slide(64'sh200000);
      if (o < 64'sh10000 || (o >= 64'sh12000 && o < 64'sh18000) || o >= 64'sh1a000) begin
        if (counts) begin
          if (!rev2) cert_hits = bump(cert_hits, 1);
          else gate_hits = bump(gate_hits, 1);
        end
        if (wr && o < 64'sh10000) r.drop = 1'b1;
      end else if (!wr && prot) begin
        r.ovr = 1'b1;
        r.pattern = word ? PATTERN_WORD : PATTERN_BYTE;
      end
    end else begin
      cert_hits = '0;
      gate_hits = '0;
      port_hits = '0;
      overrun_hits = '0;
    end
    r.prot = prot;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      rev2 = 1'b0;
      base = FLASH_BASE_RST;
      fsize = FLASH_SIZE_RST;
      page_nx = '0;
      high_nx = 1'b0;
      exec_pages = EXEC_LIMIT_RST;
      prot = 1'b0;
      arch_bits = '0;
      cert_hits = '0;
      gate_hits = '0;
      port_hits = '0;
      overrun_hits = '0;
      verdicts_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HW_MODE:     rev2 = cfg_data[0];
          CFG_FLASH_BASE:  base = cfg_data[23:0];
          CFG_FLASH_SIZE:  fsize = cfg_data[22:0];
          CFG_RAM_NOEXEC:  page_nx = cfg_data;
          CFG_HIGH_NOEXEC: high_nx = cfg_data[0];
          CFG_EXEC_LIMIT:  exec_pages = cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with no access outstanding: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("freeze", want.freeze, m_axis_tdata[0]);
          check_field("violation", want.vio, m_axis_tdata[2:1]);
          check_field("read_override", want.ovr, m_axis_tdata[3]);
          check_field("override_data", want.pattern, m_axis_tdata[19:4]);
          check_field("write_drop", want.drop, m_axis_tdata[20]);
          check_field("protect_on", want.prot, m_axis_tdata[21]);
          results++;
          if (want.freeze) freezes++;
          if (want.ovr) overrides++;
          if (want.drop) drops++;
          if (want.vio == VIO_ARCHIVE) archive_hits++;
          if (want.vio == VIO_RAM_EXEC) ram_exec_hits++;
          if (want.vio == VIO_FL_EXEC) flash_exec_hits++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdicts_due.push_back(judge_access(func_t'(s_axis_tuser), s_axis_tdata));
      end
    end
    pending <= verdicts_due.size();
  end

endmodule

// ----- tb/flash_memory_protection_unit_tb.sv -----
// Testbench top: drives accesses and register writes into the protection unit, gives the verdict.
`timescale 1ns / 1ps
module flash_memory_protection_unit_tb;
  import fmpu_pkg::*;

  localparam int HOLD_CYCLES    = 40;    // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES   = 4;     // extra wait after the last result beat
  localparam int WATCHDOG_LIMIT = 2000;  // far above the hold-off plus any gap
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 45;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // [23:0] addr
  logic [1:0]  s_axis_tuser = '0;    // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] freeze, [2:1] violation, [3] read_override, [19:4] override_data,
  // [20] write_drop, [21] protect_on, [23:22] zero
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int mismatches;
  int pending;
  int results;
  int freezes;
  int overrides;
  int drops;
  int archive_hits;
  int ram_exec_hits;
  int flash_exec_hits;

  logic        gaps_on = 1'b1;    // random idling on both sides
  logic        hold_req = 1'b0;   // ask the receiver for its one long hold-off
  logic        held = 1'b0;
  int          idle_cycles = 0;
  int          items_sent = 0;
  int          settings = 0;
  logic [23:0] cur_base = FLASH_BASE_RST;

  flash_memory_protection_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  flash_memory_protection_unit_checker chk (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results         (results),
    .freezes         (freezes),
    .overrides       (overrides),
    .drops           (drops),
    .archive_hits    (archive_hits),
    .ram_exec_hits   (ram_exec_hits),
    .flash_exec_hits (flash_exec_hits)
  );

  always #6 clk = ~clk;

  // Watchdog: end the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL flash_memory_protection_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: random stalls, one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 32);
    end
  end

  // Offer one access and hold it until the block takes it. Valid stays high
  // after the beat so back-to-back accesses need no extra edge.
  task automatic send_access(input func_t fn, input logic [23:0] a);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= a;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every access has produced its result beat.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all six registers while the block is idle.
  task automatic load_setting(input logic rev, input logic [23:0] fb, input logic [22:0] fs,
                              input logic [63:0] nx, input logic hinx, input logic [7:0] lim);
    settle();
    put_reg(CFG_HW_MODE, {63'd0, rev});
    put_reg(CFG_FLASH_BASE, {40'd0, fb});
    put_reg(CFG_FLASH_SIZE, {41'd0, fs});
    put_reg(CFG_RAM_NOEXEC, nx);
    put_reg(CFG_HIGH_NOEXEC, {63'd0, hinx});
    put_reg(CFG_EXEC_LIMIT, {56'd0, lim});
    cfg_valid <= 1'b0;
    cur_base = fb;
    settings++;
  endtask

  // Address of a fixed-layout offset moved by the current flash base.
  function automatic logic [23:0] slid_addr(input int ofs);
    return 24'(int'(cur_base) - 32'h200000 + ofs);
  endfunction

  // Pick an address in the certificate window, in its counting part or in its gaps.
  function automatic logic [23:0] cert_addr(input bit counting);
    int o;
    if (counting) begin
      case ($urandom_range(0, 2))
        0:       o = $urandom_range(0, 32'hffff);
        1:       o = $urandom_range(32'h12000, 32'h17fff);
        default: o = $urandom_range(32'h1a000, 32'h1ffff);
      endcase
    end else begin
      o = $urandom_range(0, 1) ? $urandom_range(32'h10000, 32'h11fff)
                               : $urandom_range(32'h18000, 32'h19fff);
    end
    if ($urandom_range(0, 3) != 0) o = o & ~1;
    return slid_addr(32'h200000 + o);
  endfunction

  // One random burst: mostly well-formed access sequences, some noise.
  task automatic run_burst();
    int          pick;
    int          n;
    int          i;
    logic [23:0] a;
    pick = $urandom_range(0, 99);
    n = $urandom_range(3, 6);
    if (pick < 25) begin
      // noise: any kind at any address
      for (i = 0; i < n - 2; i++) send_access(func_t'($urandom_range(0, 3)), 24'($urandom));
    end else if (pick < 45) begin
      // unlock or lock: count in the certificate window, hit the enable port,
      // then read the gaps that may now return the pattern
      for (i = 0; i < n - 2; i++) send_access(func_t'($urandom_range(1, 3)), cert_addr(1));
      send_access(func_t'($urandom_range(1, 3)),
                  24'(32'h1c0000 + $urandom_range(0, 32'h3ffff)));
      for (i = 0; i < 2; i++) send_access(func_t'($urandom_range(1, 2)), cert_addr(0));
    end else if (pick < 57) begin
      // repeated enable-port hits without a prior unlock
      for (i = 0; i < n; i++) begin
        a = 24'(32'h1c0000 + $urandom_range(0, 32'h3ffff));
        if ($urandom_range(0, 4) != 0) a[0] = 1'b0;
        send_access(func_t'($urandom_range(1, 3)), a);
      end
    end else if (pick < 70) begin
      // fetches into the archive window, mostly even
      for (i = 0; i < n; i++) begin
        a = slid_addr($urandom_range(32'h390000, 32'h3fffff));
        if ($urandom_range(0, 4) != 0) a[0] = 1'b0;
        send_access(FN_FETCH, a);
      end
    end else if (pick < 85) begin
      // fetches across RAM, high RAM and the flash execution window
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0:       a = 24'($urandom_range(0, 32'h03ffff));
          1:       a = 24'($urandom_range(32'h040000, 32'h1fffff));
          default: a = slid_addr($urandom_range(32'h200000, 32'h600000));
        endcase
        send_access(FN_FETCH, a);
      end
    end else begin
      // archive-limit writes and reads, then a fetch
      for (i = 0; i < n - 1; i++) begin
        send_access(func_t'($urandom_range(1, 3)),
                    24'($urandom_range(32'h040000, 32'h0fffff)));
      end
      send_access(FN_FETCH, slid_addr($urandom_range(32'h390000, 32'h3fffff)) & 24'hfffffe);
    end
  endtask

  initial begin : stimulus
    int          ph;
    int          goal;
    logic [23:0] fb;
    logic [22:0] fs;
    logic [7:0]  lim;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first revision with reset-value registers.
    load_setting(1'b0, FLASH_BASE_RST, FLASH_SIZE_RST, 64'd0, 1'b0, EXEC_LIMIT_RST);
    send_access(FN_WRITE, 24'h040000);       // set archive-limit bit 0
    send_access(FN_WRITE, 24'h0fffff);       // set bit 2
    send_access(FN_READ_BYTE, 24'h0c0000);   // clear bit 2 again
    send_access(FN_FETCH, 24'h3a0000);       // archive window starts one page up
    send_access(FN_FETCH, 24'h3a0001);       // odd fetch does not count
    send_access(FN_FETCH, 24'h3ffffe);
    send_access(FN_FETCH, 24'h3c0000);
    send_access(FN_FETCH, 24'h3f0000);       // fourth count: archive freeze
    send_access(FN_READ_BYTE, 24'h200000);   // certificate counting
    send_access(FN_READ_WORD, 24'h200001);   // odd word read counts as usual
    send_access(FN_WRITE, 24'h20fffe);       // boot code write: dropped
    send_access(FN_READ_BYTE, 24'h21ffff);   // odd byte, no count
    send_access(FN_READ_BYTE, 24'h1c0000);   // unlock: protect on
    send_access(FN_READ_BYTE, 24'h210000);   // byte pattern
    send_access(FN_READ_WORD, 24'h219ffe);   // word pattern
    send_access(FN_READ_BYTE, 24'h180000);   // screen window, no effect
    repeat (4) send_access(FN_WRITE, 24'h1c0002);  // port hits up to a data freeze
    send_access(FN_READ_BYTE, 24'h100000);   // unlisted: clear every counter

    // Directed part, second revision: page and high-RAM execution guards.
    load_setting(1'b1, FLASH_BASE_RST, FLASH_SIZE_RST, 64'h8000_0000_0000_0001, 1'b1,
                 EXEC_LIMIT_RST);
    send_access(FN_FETCH, 24'h000000);       // page 0 forbidden
    send_access(FN_FETCH, 24'h03ffff);       // page 63 forbidden
    send_access(FN_FETCH, 24'h100000);       // high RAM forbidden
    send_access(FN_FETCH, 24'h38fffe);       // last allowed flash page
    send_access(FN_FETCH, 24'h390000);       // first forbidden flash page
    repeat (4) send_access(FN_READ_WORD, 24'h1c0000);  // word hits unlock on their own

    // Random part: one register setting per phase, the first two at the extremes.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_setting(1'b0, 24'h200000, 23'd0, 64'd0, 1'b0, 8'd0);
        1: load_setting(1'b1, 24'hffffff, 23'h400000, '1, 1'b1, 8'hff);
        default: begin
          fb = $urandom_range(0, 1) ? 24'(32'h200000 + $urandom_range(0, 32) * 32'h10000)
                                    : 24'($urandom_range(32'h200000, 32'hffffff));
          fs = $urandom_range(0, 1) ? FLASH_SIZE_RST : 23'($urandom_range(0, 32'h400000));
          lim = $urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 40))
                                          : 8'($urandom_range(0, 255));
          load_setting(1'($urandom_range(0, 1)), fb, fs, {$urandom, $urandom},
                       1'($urandom_range(0, 1)), lim);
        end
      endcase
      // hold the receiver off early in one phase so the input stalls;
      // run one whole phase with no idling at all
      if (ph == 2) hold_req <= 1'b1;
      gaps_on <= (ph != 3);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) run_burst();
    end

    settle();
    $display("covered %0d accesses under %0d register settings: %0d freezes, %0d pattern reads,"
             , results, settings, freezes, overrides);
    $display("  %0d dropped writes, violations archive %0d / RAM exec %0d / flash exec %0d",
             drops, archive_hits, ram_exec_hits, flash_exec_hits);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS flash_memory_protection_unit");
    end else begin
      $display("FAIL flash_memory_protection_unit");
    end
    $finish;
  end

endmodule
